// ----- hdl/spn_pkg.sv -----
// Shared constants for the triangle scanline span unit.
// No dependencies; used by spn_finish, the top level and the testbench.
package spn_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int COLOR_W = 32;

endpackage

// ----- hdl/spn_sort.sv -----
// First pipeline stage: orders the three vertices by y.
// Depends on no package items; parameterized by coordinate width.
module spn_sort #(
  parameter int N = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  logic         v_in,
  input  logic [N-1:0] ax, ay, bx, by, cx, cy, row,
  output logic         vld,
  output logic [N-1:0] x0, y0, x1, y1, x2, y2, r
);

  logic [N-1:0] sx0, sy0, sx1, sy1, sx2, sy2;
  logic [N-1:0] tx0, ty0, tx1, ty1, tx2, ty2;
  logic [N-1:0] ux0, uy0, ux1, uy1, ux2, uy2;

  // Three compare-and-swaps, each only on strictly greater y.
  always_comb begin
    sx0 = ax; sy0 = ay; sx1 = bx; sy1 = by; sx2 = cx; sy2 = cy;
    if (ay > by) begin
      sx0 = bx; sy0 = by; sx1 = ax; sy1 = ay;
    end
    tx0 = sx0; ty0 = sy0; tx1 = sx1; ty1 = sy1; tx2 = sx2; ty2 = sy2;
    if (sy0 > sy2) begin
      tx0 = sx2; ty0 = sy2; tx2 = sx0; ty2 = sy0;
    end
    ux0 = tx0; uy0 = ty0; ux1 = tx1; uy1 = ty1; ux2 = tx2; uy2 = ty2;
    if (ty1 > ty2) begin
      ux1 = tx2; uy1 = ty2; ux2 = tx1; uy2 = ty1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= v_in;
    end
    if (load && v_in) begin
      x0 <= ux0; y0 <= uy0; x1 <= ux1; y1 <= uy1; x2 <= ux2; y2 <= uy2;
      r  <= row;
    end
  end

endmodule

// ----- hdl/spn_setup.sv -----
// Second stage: picks the edges for the row, forms each edge's product
// numerator and divisor, and the flat-triangle extent. No package use.
module spn_setup #(
  parameter int N = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic           v_in,
  input  logic [N-1:0]   x0, y0, x1, y1, x2, y2, r,
  output logic           vld,
  output logic [2*N-1:0] num_l, num_s,
  output logic [N-1:0]   den_l, den_s,
  output logic           neg_l, neg_s,
  output logic [4*N+1:0] side
);

  logic         covered, flat, use_l, use_s;
  logic [N-1:0] s_xs, s_xe, s_ys, s_ye, base_s;
  logic [N-1:0] t_l, t_s, adx_l, adx_s, dy_l, dy_s, mn, mx;
  logic         ng_l, ng_s;

  always_comb begin
    covered = (r >= y0) && (r <= y2);
    flat    = (y2 == y0);
    if (r < y1) begin
      s_xs = x0; s_ys = y0; s_xe = x1; s_ye = y1;
    end else begin
      s_xs = x1; s_ys = y1; s_xe = x2; s_ye = y2;
    end
    // On the middle row the short edge is exactly the middle x.
    use_l  = covered && !flat;
    use_s  = use_l && (r != y1);
    base_s = (r == y1) ? x1 : s_xs;
    t_l    = use_l ? (r - y0) : '0;
    t_s    = use_s ? (r - s_ys) : '0;
    dy_l   = use_l ? (y2 - y0) : N'(1);
    dy_s   = use_s ? (s_ye - s_ys) : N'(1);
    ng_l   = x2 < x0;
    ng_s   = s_xe < s_xs;
    adx_l  = ng_l ? (x0 - x2) : (x2 - x0);
    adx_s  = ng_s ? (s_xs - s_xe) : (s_xe - s_xs);
    mn = x0; mx = x0;
    if (x1 < mn) mn = x1;
    if (x2 < mn) mn = x2;
    if (x1 > mx) mx = x1;
    if (x2 > mx) mx = x2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= v_in;
    end
    if (load && v_in) begin
      num_l <= (2*N)'(t_l) * (2*N)'(adx_l);
      num_s <= (2*N)'(t_s) * (2*N)'(adx_s);
      den_l <= dy_l;
      den_s <= dy_s;
      neg_l <= ng_l;
      neg_s <= ng_s;
      side  <= {covered, flat, mn, mx, x0, base_s};
    end
  end

endmodule

// ----- hdl/spn_div.sv -----
// Two-lane restoring divider, one quotient bit per pipeline stage.
// No package use; the quotient is known to fit in N bits.
module spn_div #(
  parameter int N  = 10,
  parameter int SW = 42
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [N-1:0]   load,
  input  logic           v_in,
  input  logic [2*N-1:0] num_l, num_s,
  input  logic [N-1:0]   den_l, den_s,
  input  logic           neg_l, neg_s,
  input  logic [SW-1:0]  side_in,
  output logic [N-1:0]   vld,
  output logic [N-1:0]   q_l, q_s,
  output logic           rnz_l, rnz_s,
  output logic           ng_l, ng_s,
  output logic [SW-1:0]  side_out
);

  // Stage j output registers.
  logic [2*N-1:0] rl [N];
  logic [2*N-1:0] rs [N];
  logic [N-1:0]   dl [N];
  logic [N-1:0]   ds [N];
  logic [N-1:0]   ql [N];
  logic [N-1:0]   qs [N];
  logic           nl [N];
  logic           ns [N];
  logic [SW-1:0]  sd [N];
  logic           vv [N];

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int B = N - 1 - j;
    logic [2*N-1:0] pr_l, pr_s, shl, shs;
    logic [N-1:0]   pd_l, pd_s, pq_l, pq_s;
    logic           pn_l, pn_s, pv;
    logic [SW-1:0]  psd;
    logic           gel, ges;

    if (j == 0) begin : g_first
      assign pr_l = num_l;
      assign pr_s = num_s;
      assign pd_l = den_l;
      assign pd_s = den_s;
      assign pq_l = '0;
      assign pq_s = '0;
      assign pn_l = neg_l;
      assign pn_s = neg_s;
      assign psd  = side_in;
      assign pv   = v_in;
    end else begin : g_next
      assign pr_l = rl[j-1];
      assign pr_s = rs[j-1];
      assign pd_l = dl[j-1];
      assign pd_s = ds[j-1];
      assign pq_l = ql[j-1];
      assign pq_s = qs[j-1];
      assign pn_l = nl[j-1];
      assign pn_s = ns[j-1];
      assign psd  = sd[j-1];
      assign pv   = vv[j-1];
    end

    assign shl = {{N{1'b0}}, pd_l} << B;
    assign shs = {{N{1'b0}}, pd_s} << B;
    assign gel = pr_l >= shl;
    assign ges = pr_s >= shs;

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[j] <= 1'b0;
      end else if (load[j]) begin
        vv[j] <= pv;
      end
      if (load[j] && pv) begin
        rl[j] <= gel ? (pr_l - shl) : pr_l;
        rs[j] <= ges ? (pr_s - shs) : pr_s;
        ql[j] <= pq_l | (N'(gel) << B);
        qs[j] <= pq_s | (N'(ges) << B);
        dl[j] <= pd_l;
        ds[j] <= pd_s;
        nl[j] <= pn_l;
        ns[j] <= pn_s;
        sd[j] <= psd;
      end
    end

    assign vld[j] = vv[j];
  end

  assign q_l      = ql[N-1];
  assign q_s      = qs[N-1];
  assign rnz_l    = rl[N-1] != '0;
  assign rnz_s    = rs[N-1] != '0;
  assign ng_l     = nl[N-1];
  assign ng_s     = ns[N-1];
  assign side_out = sd[N-1];

endmodule

// ----- hdl/spn_finish.sv -----
// Last stage: floor correction, edge x values, span ordering, output register.
// Uses spn_pkg for the colour width.
module spn_finish #(
  parameter int N = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic                      v_in,
  input  logic [N-1:0]              q_l, q_s,
  input  logic                      rnz_l, rnz_s,
  input  logic                      ng_l, ng_s,
  input  logic [4*N+1:0]            side,
  input  logic [spn_pkg::COLOR_W-1:0] color,
  output logic                      vld,
  output logic                      covered,
  output logic [N-1:0]              left,
  output logic [N-1:0]              right,
  output logic [spn_pkg::COLOR_W-1:0] color_out
);

  logic         cov, flat;
  logic [N-1:0] mn, mx, base_l, base_s, xl, xs, lo, hi;

  always_comb begin
    {cov, flat, mn, mx, base_l, base_s} = side;
    // Negative quotients round toward minus infinity.
    xl = ng_l ? (base_l - (q_l + N'(rnz_l))) : (base_l + q_l);
    xs = ng_s ? (base_s - (q_s + N'(rnz_s))) : (base_s + q_s);
    if (flat) begin
      lo = mn; hi = mx;
    end else if (xl < xs) begin
      lo = xl; hi = xs;
    end else begin
      lo = xs; hi = xl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= v_in;
    end
    if (load && v_in) begin
      covered   <= cov;
      left      <= cov ? lo : '0;
      right     <= cov ? hi : '0;
      color_out <= cov ? color : '0;
    end
  end

endmodule

// ----- hdl/triangle_scanline_span_unit.sv -----
// Triangle scanline span unit: top level, flow control and colour register.
// Instantiates spn_sort, spn_setup, spn_div and spn_finish; uses spn_pkg.
//
//   channel   direction  handshake             payload
//   request   in         req_valid/req_stall   vertex_a..c x/y, row_index
//   result    out        rsp_valid/rsp_stall   row_covered, span_left/right, span_color
//   config    in         cfg_write             cfg_data (fill colour)
//
// One request enters per clock while req_stall is low, and passes COORD_BITS + 3
// registers (sort, setup with the multiply, one divider stage per quotient bit,
// finish) on its way to the result.
// Reset (rst, synchronous) clears all stage valid bits and the fill colour.
// Each stage holds while its successor is full and stalled, so bubbles close up
// and a stall on the result side only backs up as far as there is no room.
module triangle_scanline_span_unit #(
  parameter int COORD_BITS = spn_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [COORD_BITS-1:0]         vertex_a_x,
  input  logic [COORD_BITS-1:0]         vertex_a_y,
  input  logic [COORD_BITS-1:0]         vertex_b_x,
  input  logic [COORD_BITS-1:0]         vertex_b_y,
  input  logic [COORD_BITS-1:0]         vertex_c_x,
  input  logic [COORD_BITS-1:0]         vertex_c_y,
  input  logic [COORD_BITS-1:0]         row_index,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          row_covered,
  output logic [COORD_BITS-1:0]         span_left,
  output logic [COORD_BITS-1:0]         span_right,
  output logic [spn_pkg::COLOR_W-1:0]   span_color,
  input  logic                          cfg_write,
  input  logic [spn_pkg::COLOR_W-1:0]   cfg_data
);

  localparam int N   = COORD_BITS;
  localparam int SW  = 4 * N + 2;
  localparam int NST = N + 3;

  logic [spn_pkg::COLOR_W-1:0] fill_color;

  // Stage valid bits, in pipeline order, and per-stage load enables.
  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  logic [N-1:0]   x0, y0, x1, y1, x2, y2, r;
  logic [2*N-1:0] num_l, num_s;
  logic [N-1:0]   den_l, den_s, q_l, q_s;
  logic           neg_l, neg_s, rnz_l, rnz_s, ng_l, ng_s;
  logic [SW-1:0]  side, side_d;
  logic [N-1:0]   div_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_color <= '0;
    end else if (cfg_write) begin
      fill_color <= cfg_data;
    end
  end

  // A stage may load when it is empty or its contents move on this cycle.
  assign rdy[NST] = !rsp_stall;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end

  assign req_stall = !rdy[0];

  spn_sort #(.N(N)) u_sort (
    .clk(clk), .rst(rst), .load(rdy[0]), .v_in(req_valid),
    .ax(vertex_a_x), .ay(vertex_a_y), .bx(vertex_b_x), .by(vertex_b_y),
    .cx(vertex_c_x), .cy(vertex_c_y), .row(row_index),
    .vld(v[0]), .x0(x0), .y0(y0), .x1(x1), .y1(y1), .x2(x2), .y2(y2), .r(r)
  );

  spn_setup #(.N(N)) u_setup (
    .clk(clk), .rst(rst), .load(rdy[1]), .v_in(v[0]),
    .x0(x0), .y0(y0), .x1(x1), .y1(y1), .x2(x2), .y2(y2), .r(r),
    .vld(v[1]), .num_l(num_l), .num_s(num_s), .den_l(den_l), .den_s(den_s),
    .neg_l(neg_l), .neg_s(neg_s), .side(side)
  );

  spn_div #(.N(N), .SW(SW)) u_div (
    .clk(clk), .rst(rst), .load(rdy[N+1:2]), .v_in(v[1]),
    .num_l(num_l), .num_s(num_s), .den_l(den_l), .den_s(den_s),
    .neg_l(neg_l), .neg_s(neg_s), .side_in(side),
    .vld(div_v), .q_l(q_l), .q_s(q_s), .rnz_l(rnz_l), .rnz_s(rnz_s),
    .ng_l(ng_l), .ng_s(ng_s), .side_out(side_d)
  );

  assign v[N+1:2] = div_v;

  spn_finish #(.N(N)) u_finish (
    .clk(clk), .rst(rst), .load(rdy[NST-1]), .v_in(v[N+1]),
    .q_l(q_l), .q_s(q_s), .rnz_l(rnz_l), .rnz_s(rnz_s),
    .ng_l(ng_l), .ng_s(ng_s), .side(side_d), .color(fill_color),
    .vld(v[NST-1]), .covered(row_covered), .left(span_left),
    .right(span_right), .color_out(span_color)
  );

  assign rsp_valid = v[NST-1];

endmodule

// ----- bench/triangle_scanline_span_unit_tb.sv -----
// Testbench for the triangle scanline span unit: drives vertex/row requests,
// predicts each span with an integer model and checks every result in order.
// Depends on spn_pkg and the triangle_scanline_span_unit RTL.
`timescale 1ns / 100ps

module triangle_scanline_span_unit_tb;

  localparam int CW = spn_pkg::COORD_BITS_DEF;
  localparam int LATENCY = CW + 3;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    coord_t ax, ay, bx, by, cx, cy, row;
  } tri_req_t;

  typedef struct packed {
    logic covered;
    coord_t left, right;
    logic [spn_pkg::COLOR_W-1:0] color;
  } span_t;

  // Span predictor and store of expected spans.
  class span_scoreboard;
    span_t pending_spans[$];
    logic [spn_pkg::COLOR_W-1:0] fill_color;
    int errors;

    function new();
      fill_color = '0;
      errors = 0;
    endfunction

    // Floor of xs + (r - ys) * (xe - xs) / (ye - ys), with ye > ys.
    function automatic longint edge_x(longint xs, longint ys, longint xe, longint ye,
                                      longint r);
      longint n, d;
      n = (r - ys) * (xe - xs);
      d = ye - ys;
      if (n >= 0) return xs + n / d;
      return xs - ((-n + d - 1) / d);
    endfunction

    function void note_request(tri_req_t q);
      longint x[3], y[3], t, r, xl, xs, lo, hi;
      span_t s;
      x[0] = q.ax; y[0] = q.ay; x[1] = q.bx; y[1] = q.by; x[2] = q.cx; y[2] = q.cy;
      r = q.row;
      // Same three compare-and-swaps as the hardware; strict greater-than only.
      if (y[0] > y[1]) begin
        t = x[0]; x[0] = x[1]; x[1] = t; t = y[0]; y[0] = y[1]; y[1] = t;
      end
      if (y[0] > y[2]) begin
        t = x[0]; x[0] = x[2]; x[2] = t; t = y[0]; y[0] = y[2]; y[2] = t;
      end
      if (y[1] > y[2]) begin
        t = x[1]; x[1] = x[2]; x[2] = t; t = y[1]; y[1] = y[2]; y[2] = t;
      end
      s = '0;
      if (r >= y[0] && r <= y[2]) begin
        if (y[2] == y[0]) begin
          // Zero-height triangle: span covers all three vertex x values.
          lo = x[0]; hi = x[0];
          for (int i = 1; i < 3; i++) begin
            if (x[i] < lo) lo = x[i];
            if (x[i] > hi) hi = x[i];
          end
        end else begin
          xl = edge_x(x[0], y[0], x[2], y[2], r);
          if (r < y[1]) xs = edge_x(x[0], y[0], x[1], y[1], r);
          else if (r > y[1]) xs = edge_x(x[1], y[1], x[2], y[2], r);
          else xs = x[1];
          lo = (xl < xs) ? xl : xs;
          hi = (xl < xs) ? xs : xl;
        end
        s.covered = 1'b1;
        s.left = coord_t'(lo);
        s.right = coord_t'(hi);
        s.color = fill_color;
      end
      pending_spans.push_back(s);
    endfunction

    function void check_span(span_t got);
      span_t exp_s;
      if (pending_spans.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_s = pending_spans.pop_front();
      if (got.covered !== exp_s.covered) begin
        $display("%0t: row_covered exp %0d got %0d", $time, exp_s.covered, got.covered);
        errors++;
      end
      if (got.left !== exp_s.left) begin
        $display("%0t: span_left exp %0d got %0d", $time, exp_s.left, got.left);
        errors++;
      end
      if (got.right !== exp_s.right) begin
        $display("%0t: span_right exp %0d got %0d", $time, exp_s.right, got.right);
        errors++;
      end
      if (got.color !== exp_s.color) begin
        $display("%0t: span_color exp %h got %h", $time, exp_s.color, got.color);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  coord_t vertex_a_x = '0, vertex_a_y = '0, vertex_b_x = '0, vertex_b_y = '0;
  coord_t vertex_c_x = '0, vertex_c_y = '0, row_index = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic row_covered;
  coord_t span_left, span_right;
  logic [spn_pkg::COLOR_W-1:0] span_color;
  logic cfg_write = 1'b0;
  logic [spn_pkg::COLOR_W-1:0] cfg_data = '0;

  span_scoreboard board = new();

  // Idle rates in percent for the two sides; changed between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;
  int quiet_cycles = 0;
  bit timed_out = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  triangle_scanline_span_unit #(.COORD_BITS(CW)) i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .vertex_a_x(vertex_a_x), .vertex_a_y(vertex_a_y),
    .vertex_b_x(vertex_b_x), .vertex_b_y(vertex_b_y),
    .vertex_c_x(vertex_c_x), .vertex_c_y(vertex_c_y),
    .row_index(row_index),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .row_covered(row_covered), .span_left(span_left), .span_right(span_right),
    .span_color(span_color),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  // Result side: sample at the edge, then pick the next stall value. A long
  // hold-off, when requested, keeps stall high so the pipeline fills up.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      board.check_span({row_covered, span_left, span_right, span_color});
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: counts cycles outside reset and hold-off in which neither channel moves a request or result.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || rst
        || hold_off_cycles > 0)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one request; waits for acceptance. Gaps come before the request so
  // valid stays high across back-to-back requests.
  task automatic send_request(tri_req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    vertex_a_x <= q.ax; vertex_a_y <= q.ay;
    vertex_b_x <= q.bx; vertex_b_y <= q.by;
    vertex_c_x <= q.cx; vertex_c_y <= q.cy;
    row_index <= q.row;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_request(q);
  endtask

  // Wait for every expected span, then let the pipeline settle.
  task automatic drain();
    req_valid <= 1'b0;
    while (board.pending_spans.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_color(logic [spn_pkg::COLOR_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.fill_color = value;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Mostly rows inside the triangle's y extent, with some outside it.
  function automatic tri_req_t rand_request();
    tri_req_t q;
    int lo, hi;
    q.ax = rand_coord(); q.bx = rand_coord(); q.cx = rand_coord();
    case ($urandom_range(7))
      0: begin  // zero-height
        q.ay = coord_t'($urandom); q.by = q.ay; q.cy = q.ay;
      end
      1: begin  // flat bottom or top
        q.ay = coord_t'($urandom); q.by = q.ay; q.cy = coord_t'($urandom);
      end
      2: begin  // small triangle
        q.ay = coord_t'($urandom); q.by = q.ay + coord_t'($urandom_range(6));
        q.cy = q.ay + coord_t'($urandom_range(6));
      end
      default: begin
        q.ay = rand_coord(); q.by = rand_coord(); q.cy = rand_coord();
      end
    endcase
    lo = q.ay; hi = q.ay;
    if (q.by < lo) lo = q.by;
    if (q.cy < lo) lo = q.cy;
    if (q.by > hi) hi = q.by;
    if (q.cy > hi) hi = q.cy;
    if ($urandom_range(9) < 8) q.row = coord_t'($urandom_range(hi, lo));
    else q.row = rand_coord();
    return q;
  endfunction

  function automatic tri_req_t make_req(int ax, int ay, int bx, int by, int cx, int cy,
                                        int row);
    tri_req_t q;
    q.ax = coord_t'(ax); q.ay = coord_t'(ay); q.bx = coord_t'(bx); q.by = coord_t'(by);
    q.cx = coord_t'(cx); q.cy = coord_t'(cy); q.row = coord_t'(row);
    return q;
  endfunction

  initial begin
    tri_req_t directed[$];
    int max_c;
    max_c = (1 << CW) - 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: extremes, rows outside, zero height, flat top and bottom,
    // the middle vertex's own row, negative slopes and input orders that swap.
    directed.push_back(make_req(0, 0, max_c, max_c, 0, max_c, max_c));
    directed.push_back(make_req(0, 0, max_c, max_c, 0, max_c, 0));
    directed.push_back(make_req(max_c, 0, 0, max_c, max_c, max_c, 512));
    directed.push_back(make_req(5, 10, 6, 20, 7, 30, 9));
    directed.push_back(make_req(5, 10, 6, 20, 7, 30, 31));
    directed.push_back(make_req(300, 40, 10, 40, max_c, 40, 40));
    directed.push_back(make_req(300, 40, 10, 40, max_c, 40, 41));
    directed.push_back(make_req(100, 50, 200, 50, 150, 90, 50));
    directed.push_back(make_req(100, 50, 200, 50, 150, 90, 70));
    directed.push_back(make_req(100, 90, 200, 90, 150, 50, 90));
    directed.push_back(make_req(100, 90, 200, 90, 150, 50, 60));
    directed.push_back(make_req(400, 300, 100, 200, 900, 100, 200));
    directed.push_back(make_req(400, 300, 100, 200, 900, 100, 150));
    directed.push_back(make_req(400, 300, 100, 200, 900, 100, 250));
    directed.push_back(make_req(max_c, max_c, 0, 0, 1, 3, 1));
    directed.push_back(make_req(7, 3, 0, 0, max_c, max_c, 2));
    directed.push_back(make_req(0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_req(max_c, max_c, max_c, max_c, max_c, max_c, max_c));
    directed.push_back(make_req(682, 341, 341, 682, 0, 1023, 1000));
    foreach (directed[i]) send_request(directed[i]);
    drain();

    write_color('1);
    for (int i = 0; i < 20; i++) send_request(directed[i % directed.size()]);
    drain();

    // Sender idles rarely, receiver often.
    write_color(32'hA5C3_0F69);
    send_idle_pct = 18; recv_idle_pct = 85;
    repeat (150) send_request(rand_request());
    drain();

    // The other way round.
    write_color(32'h5A3C_F096);
    send_idle_pct = 85; recv_idle_pct = 18;
    repeat (120) send_request(rand_request());
    drain();

    // Full rate, with one long receiver hold-off to fill the pipeline.
    write_color('0);
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_off_cycles = 3 * LATENCY + 20;
    repeat (100) send_request(rand_request());
    drain();
    write_color($urandom);
    repeat (100) send_request(rand_request());
    drain();

    if (board.errors == 0 && board.pending_spans.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/spn_pkg.sv
hdl/spn_sort.sv
hdl/spn_setup.sv
hdl/spn_div.sv
hdl/spn_finish.sv
hdl/triangle_scanline_span_unit.sv
bench/triangle_scanline_span_unit_tb.sv
